// ===== rtl/metp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// metp_pkg
// Shared widths, constants and control types for the escape-time pixel block.
// ----------------------------------------------------------------------------
package metp_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 28;

  localparam int PORT_COORD_BITS = 12;
  localparam int COL_BITS    = (COORD_BITS < PORT_COORD_BITS) ? COORD_BITS : PORT_COORD_BITS;
  localparam int ORIGIN_BITS = 32;
  localparam int STEP_BITS   = 31;
  localparam int ITER_BITS   = 16;
  localparam int SHADE_BITS  = 8;
  localparam int NUM_BITS    = ITER_BITS + SHADE_BITS;
  localparam int ARGB_BITS   = 32;

  // c = origin +/- coord*step
  localparam int CPROD_BITS  = COL_BITS + STEP_BITS;
  localparam int C_BITS      = ((ORIGIN_BITS > CPROD_BITS) ? ORIGIN_BITS : CPROD_BITS) + 2;

  // z components stay within +/-2 between iterations
  localparam int Z_BITS      = FRAC_BITS + 3;
  localparam int P_BITS      = 2 * Z_BITS;
  localparam int SH_BITS     = P_BITS + 1 - FRAC_BITS;
  localparam int N_BITS      = ((SH_BITS > C_BITS) ? SH_BITS : C_BITS) + 1;

  localparam logic signed [N_BITS-1:0] TWO_FX     = N_BITS'(2) << FRAC_BITS;
  localparam logic signed [N_BITS-1:0] NEG_TWO_FX = -TWO_FX;
  localparam logic [P_BITS:0]          FOUR_SQ    = (P_BITS + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic [7:0]           ALPHA_FF   = 8'hFF;
  localparam logic [ARGB_BITS-1:0] ARGB_BLACK = 32'hFF00_0000;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_STEP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAG_STEP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER    = 3'd4;

  localparam logic signed [ORIGIN_BITS-1:0] RST_ORIGIN_REAL = -32'sd536870912;
  localparam logic signed [ORIGIN_BITS-1:0] RST_ORIGIN_IMAG = 32'sd335544320;
  localparam logic [STEP_BITS-1:0]          RST_REAL_STEP   = 31'd419430;
  localparam logic [STEP_BITS-1:0]          RST_IMAG_STEP   = 31'd419430;
  localparam logic [ITER_BITS-1:0]          RST_MAX_ITER    = 16'd256;

  typedef struct packed {
    logic load;       // form coordinate products
    logic sum;        // form c, clear z and count
    logic mul;        // square / cross products of z
    logic step;       // update z, test escape
    logic div_start;  // start shade division
  } metp_cmd_t;

  typedef struct packed {
    logic stop;
    logic esc;
    logic div_done;
  } metp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/metp_shade_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// metp_shade_div
// Restoring divider, one quotient bit per cycle, for the gray shade.
// Quotient is known to fit in SHADE_BITS (numerator < 2^SHADE_BITS * divisor).
// ----------------------------------------------------------------------------
module metp_shade_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [metp_pkg::NUM_BITS-1:0]   num,
  input  wire logic [metp_pkg::ITER_BITS-1:0]  den,
  output logic                                 done,
  output logic [metp_pkg::SHADE_BITS-1:0]      quot
);
  import metp_pkg::*;

  localparam int CNT_BITS = $clog2(SHADE_BITS);

  logic                  running;
  logic [CNT_BITS-1:0]   cnt;
  logic [NUM_BITS-1:0]   rem;
  logic [NUM_BITS-1:0]   dsh;
  logic                  fits;

  assign fits = (rem >= dsh);
  assign done = running && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= CNT_BITS'(SHADE_BITS - 1);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= NUM_BITS'(den) << (SHADE_BITS - 1);
      quot <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[SHADE_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/metp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// metp_datapath
// Point formation, z = z*z + c iteration, escape tests and shade division.
// ----------------------------------------------------------------------------
module metp_datapath (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire metp_pkg::metp_cmd_t                      cmd,
  output metp_pkg::metp_sts_t                           sts,
  input  wire logic [metp_pkg::PORT_COORD_BITS-1:0]     column,
  input  wire logic [metp_pkg::PORT_COORD_BITS-1:0]     row,
  input  wire logic signed [metp_pkg::ORIGIN_BITS-1:0]  origin_real,
  input  wire logic signed [metp_pkg::ORIGIN_BITS-1:0]  origin_imag,
  input  wire logic [metp_pkg::STEP_BITS-1:0]           real_step,
  input  wire logic [metp_pkg::STEP_BITS-1:0]           imag_step,
  input  wire logic [metp_pkg::ITER_BITS-1:0]           max_iter,
  output logic [metp_pkg::ARGB_BITS-1:0]                pixel_argb,
  output logic                                          escaped,
  output logic [metp_pkg::ITER_BITS-1:0]                escape_count
);
  import metp_pkg::*;

  logic [CPROD_BITS-1:0]     prod_r;
  logic [CPROD_BITS-1:0]     prod_i;
  logic signed [C_BITS-1:0]  cre;
  logic signed [C_BITS-1:0]  cim;
  logic signed [Z_BITS-1:0]  zr;
  logic signed [Z_BITS-1:0]  zi;
  logic signed [P_BITS-1:0]  rr;
  logic signed [P_BITS-1:0]  ii;
  logic signed [P_BITS-1:0]  ri;
  logic [ITER_BITS-1:0]      iter;

  logic signed [P_BITS:0]    diff;
  logic [P_BITS:0]           ri2;
  logic signed [N_BITS-1:0]  nr;
  logic signed [N_BITS-1:0]  ni;
  logic [P_BITS:0]           mag;
  logic                      mag_over;
  logic                      beyond;
  logic                      limit;
  logic                      stop;
  logic                      esc_hit;

  logic [ITER_BITS-1:0]      span;
  logic [NUM_BITS-1:0]       num;
  logic [SHADE_BITS-1:0]     shade;
  logic                      div_done;

  assign diff = (P_BITS + 1)'(rr) - (P_BITS + 1)'(ii);
  assign ri2  = {ri, 1'b0};
  assign nr   = N_BITS'($signed(diff[P_BITS:FRAC_BITS])) + N_BITS'(cre);
  assign ni   = N_BITS'($signed(ri2[P_BITS:FRAC_BITS])) + N_BITS'(cim);

  // rr, ii belong to the z left by the previous iteration
  assign mag      = (P_BITS + 1)'(rr) + (P_BITS + 1)'(ii);
  assign mag_over = (mag > FOUR_SQ);
  assign beyond   = (nr > TWO_FX) || (nr < NEG_TWO_FX) || (ni > TWO_FX) || (ni < NEG_TWO_FX);
  assign limit    = (iter == max_iter);
  assign stop     = mag_over || limit || beyond;
  assign esc_hit  = mag_over || (!limit && beyond);

  assign sts.stop     = stop;
  assign sts.esc      = esc_hit;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_r <= CPROD_BITS'(column[COL_BITS-1:0]) * CPROD_BITS'(real_step);
      prod_i <= CPROD_BITS'(row[COL_BITS-1:0]) * CPROD_BITS'(imag_step);
    end
    if (cmd.sum) begin
      cre <= C_BITS'(origin_real) + C_BITS'(prod_r);
      cim <= C_BITS'(origin_imag) - C_BITS'(prod_i);
      zr  <= '0;
      zi  <= '0;
    end
    if (cmd.mul) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.step && !stop) begin
      zr <= nr[Z_BITS-1:0];
      zi <= ni[Z_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter         <= '0;
      escaped      <= 1'b0;
      escape_count <= '0;
    end else if (cmd.sum) begin
      iter <= '0;
    end else if (cmd.step) begin
      if (stop) begin
        escaped      <= esc_hit;
        escape_count <= mag_over ? (iter - 1'b1) : iter;
      end else begin
        iter <= iter + 1'b1;
      end
    end
  end

  assign span = max_iter - escape_count;
  assign num  = {span, {SHADE_BITS{1'b0}}} - NUM_BITS'(span);

  metp_shade_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (max_iter),
    .done  (div_done),
    .quot  (shade)
  );

  assign pixel_argb = escaped ? {ALPHA_FF, shade, shade, shade} : ARGB_BLACK;

endmodule

`default_nettype wire

// ===== rtl/metp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// metp_ctrl
// Sequencer: coordinate setup, multiply / step loop, shade division, result.
// ----------------------------------------------------------------------------
module metp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      done,
  output metp_pkg::metp_cmd_t       cmd,
  input  wire metp_pkg::metp_sts_t  sts
);
  import metp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_STEP = 7'b0001000,
    ST_DIVS = 7'b0010000,
    ST_DIVW = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_STEP;
      ST_STEP: begin
        if (!sts.stop) begin
          state_next = ST_MUL;
        end else if (sts.esc) begin
          state_next = ST_DIVS;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: begin
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy          = (state != ST_IDLE);
  assign done          = (state == ST_DONE);
  assign cmd.load      = (state == ST_IDLE) && start;
  assign cmd.sum       = (state == ST_SUM);
  assign cmd.mul       = (state == ST_MUL);
  assign cmd.step      = (state == ST_STEP);
  assign cmd.div_start = (state == ST_DIVS);

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel in signed fixed point, gray ARGB out.
// ----------------------------------------------------------------------------
// One pixel at a time. A pixel is taken when start is high and busy is low;
// busy stays high until the result has been shown. Each complex iteration
// runs a multiply state, then an add / escape test state, and a pixel that
// escapes then runs the 8-step shade division. The result on pixel_argb,
// escaped and escape_count is valid in the single cycle that done is high;
// the receiver must take it then.
// Configuration writes are always ready and take effect at once; write them
// only while busy is low.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [metp_pkg::PORT_COORD_BITS-1:0]   column,
  input  wire logic [metp_pkg::PORT_COORD_BITS-1:0]   row,
  output logic                                        done,
  output logic [metp_pkg::ARGB_BITS-1:0]              pixel_argb,
  output logic                                        escaped,
  output logic [metp_pkg::ITER_BITS-1:0]              escape_count,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [metp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [metp_pkg::ORIGIN_BITS-1:0]       cfg_data
);
  import metp_pkg::*;

  logic signed [ORIGIN_BITS-1:0] origin_real;
  logic signed [ORIGIN_BITS-1:0] origin_imag;
  logic [STEP_BITS-1:0]          real_step;
  logic [STEP_BITS-1:0]          imag_step;
  logic [ITER_BITS-1:0]          max_iter;

  metp_cmd_t cmd;
  metp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real <= RST_ORIGIN_REAL;
      origin_imag <= RST_ORIGIN_IMAG;
      real_step   <= RST_REAL_STEP;
      imag_step   <= RST_IMAG_STEP;
      max_iter    <= RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_REAL: origin_real <= $signed(cfg_data);
        CFG_ORIGIN_IMAG: origin_imag <= $signed(cfg_data);
        CFG_REAL_STEP:   real_step   <= cfg_data[STEP_BITS-1:0];
        CFG_IMAG_STEP:   imag_step   <= cfg_data[STEP_BITS-1:0];
        CFG_MAX_ITER:    max_iter    <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  metp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  metp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .column       (column),
    .row          (row),
    .origin_real  (origin_real),
    .origin_imag  (origin_imag),
    .real_step    (real_step),
    .imag_step    (imag_step),
    .max_iter     (max_iter),
    .pixel_argb   (pixel_argb),
    .escaped      (escaped),
    .escape_count (escape_count)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the escape-time pixel block against a fixed-point predictor.
// ----------------------------------------------------------------------------
// Directed pixels cover the reset view, the iteration limit at zero, one and
// its maximum, points on the radius-two boundary, the coordinate and step
// extremes, and writes to unused register indexes. Random views then zoom
// around the set with random pixels and random gaps on the start side. Each
// done beat is checked field by field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module testbench;
  import metp_pkg::*;

  localparam int NUM_CFG_IDX = 1 << CFG_IDX_BITS;

  typedef struct {
    logic [PORT_COORD_BITS-1:0] col;
    logic [PORT_COORD_BITS-1:0] rw;
    logic [ARGB_BITS-1:0]       argb;
    logic                       esc;
    logic [ITER_BITS-1:0]       count;
  } pixel_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [PORT_COORD_BITS-1:0] column = '0;
  logic [PORT_COORD_BITS-1:0] row = '0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [ORIGIN_BITS-1:0]     cfg_data = '0;
  logic                       busy;
  logic                       done;
  logic [ARGB_BITS-1:0]       pixel_argb;
  logic                       escaped;
  logic [ITER_BITS-1:0]       escape_count;
  logic                       cfg_ready;

  // local copy of the view registers
  logic signed [ORIGIN_BITS-1:0] view_re = RST_ORIGIN_REAL;
  logic signed [ORIGIN_BITS-1:0] view_im = RST_ORIGIN_IMAG;
  logic [STEP_BITS-1:0]          step_re = RST_REAL_STEP;
  logic [STEP_BITS-1:0]          step_im = RST_IMAG_STEP;
  logic [ITER_BITS-1:0]          iter_limit = RST_MAX_ITER;

  pixel_t expected_px[$];
  int     mismatch_count = 0;
  bit     idle_on = 1'b1;

  mandelbrot_escape_time_pixel dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .column       (column),
    .row          (row),
    .done         (done),
    .pixel_argb   (pixel_argb),
    .escaped      (escaped),
    .escape_count (escape_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pixel_t predict_pixel(input logic [PORT_COORD_BITS-1:0] col,
                                           input logic [PORT_COORD_BITS-1:0] rw);
    pixel_t              px;
    logic signed [127:0] c_re, c_im, z_re, z_im, n_re, n_im, two_fx, four_sq;
    int unsigned         it, limit, shade;
    bit                  gone;
    two_fx  = 128'sd2 <<< FRAC_BITS;
    four_sq = 128'sd1 <<< (2 * FRAC_BITS + 2);
    c_re = view_re + $signed({1'b0, col}) * $signed({1'b0, step_re});
    c_im = view_im - $signed({1'b0, rw}) * $signed({1'b0, step_im});
    z_re = '0;
    z_im = '0;
    gone = 1'b0;
    limit = 32'(iter_limit);
    it = 0;
    while (it < limit && !gone) begin
      n_re = ((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re;
      n_im = ((z_re * z_im + z_re * z_im) >>> FRAC_BITS) + c_im;
      if (n_re > two_fx || n_re < -two_fx || n_im > two_fx || n_im < -two_fx) begin
        gone = 1'b1;
      end else begin
        z_re = n_re;
        z_im = n_im;
        if (z_re * z_re + z_im * z_im > four_sq) begin
          gone = 1'b1;
        end
      end
      if (!gone) begin
        it++;
      end
    end
    px.col = col;
    px.rw  = rw;
    if (gone) begin
      shade = (255 * (limit - it)) / limit;
      px.argb  = ARGB_BLACK | {8'h00, shade[7:0], shade[7:0], shade[7:0]};
      px.esc   = 1'b1;
      px.count = it[ITER_BITS-1:0];
    end else begin
      px.argb  = ARGB_BLACK;
      px.esc   = 1'b0;
      px.count = iter_limit;
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (expected_px.size() == 0) begin
        report_mismatch("result beat with no pixel outstanding");
      end else begin
        want = expected_px.pop_front();
        if (pixel_argb !== want.argb)
          report_mismatch($sformatf("pixel (%0d,%0d) pixel_argb %h, want %h",
                                    want.col, want.rw, pixel_argb, want.argb));
        if (escaped !== want.esc)
          report_mismatch($sformatf("pixel (%0d,%0d) escaped %b, want %b",
                                    want.col, want.rw, escaped, want.esc));
        if (escape_count !== want.count)
          report_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, want %0d",
                                    want.col, want.rw, escape_count, want.count));
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_pixel(input logic [PORT_COORD_BITS-1:0] col,
                            input logic [PORT_COORD_BITS-1:0] rw);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    column <= col;
    row    <= rw;
    do @(posedge clk); while (busy);
    expected_px.push_back(predict_pixel(col, rw));
  endtask

  // hold off new pixels until every outstanding result has come back
  task automatic drain();
    if (start) start <= 1'b0;
    while (expected_px.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_REAL: view_re = data;
      CFG_ORIGIN_IMAG: view_im = data;
      CFG_REAL_STEP:   step_re = data[STEP_BITS-1:0];
      CFG_IMAG_STEP:   step_im = data[STEP_BITS-1:0];
      CFG_MAX_ITER:    iter_limit = data[ITER_BITS-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_view(input logic [31:0] o_re, input logic [31:0] o_im,
                          input logic [31:0] s_re, input logic [31:0] s_im,
                          input logic [31:0] iters);
    drain();
    write_reg(CFG_ORIGIN_REAL, o_re, 1'b0);
    write_reg(CFG_ORIGIN_IMAG, o_im, 1'b0);
    write_reg(CFG_REAL_STEP, s_re, 1'b0);
    write_reg(CFG_IMAG_STEP, s_im, 1'b0);
    write_reg(CFG_MAX_ITER, iters, 1'b1);
  endtask

  // reset view spans -2..+4.4 real, +1.25 down to -5.1 imag, 640 pixels per unit
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1280, 12'd800);
    send_pixel(12'd640, 12'd800);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
  endtask

  task automatic test_iteration_limit();
    set_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, 32'(RST_REAL_STEP), 32'(RST_IMAG_STEP),
             32'd1);
    send_pixel(12'd1280, 12'd800);
    send_pixel(12'd0, 12'd0);
    set_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, 32'(RST_REAL_STEP), 32'(RST_IMAG_STEP),
             32'd0);
    send_pixel(12'd1280, 12'd800);
    send_pixel(12'd0, 12'd4095);
    set_view(RST_ORIGIN_REAL, RST_ORIGIN_IMAG, 32'(RST_REAL_STEP), 32'(RST_IMAG_STEP),
             32'hFFFF_FFFF);
    send_pixel(12'd1447, 12'd800);
    send_pixel(12'd1280, 12'd800);
  endtask

  task automatic test_radius_boundary();
    set_view(32'sd2 <<< FRAC_BITS, 32'd0, 32'd0, 32'd0, 32'd16);
    send_pixel(12'd0, 12'd0);
    set_view(-(32'sd2 <<< FRAC_BITS), 32'd0, 32'd0, 32'd0, 32'd16);
    send_pixel(12'd0, 12'd0);
    set_view((32'sd2 <<< FRAC_BITS) + 1, 32'd0, 32'd0, 32'd0, 32'd16);
    send_pixel(12'd0, 12'd0);
    set_view(32'sd3 <<< (FRAC_BITS - 1), 32'sd3 <<< (FRAC_BITS - 1), 32'd0, 32'd0, 32'd16);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_coord_extremes();
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd256);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd0, 12'd0);
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'hABCD_0040);
    send_pixel(12'd4095, 12'd4095);
  endtask

  task automatic test_unused_index();
    int k;
    drain();
    for (k = int'(CFG_MAX_ITER) + 1; k < NUM_CFG_IDX; k++) begin
      write_reg(CFG_IDX_BITS'(k), $urandom, k == NUM_CFG_IDX - 1);
    end
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
  endtask

  // zoomed views around the set, plus one view with fully random registers
  task automatic test_random_views();
    int          phase, k;
    int unsigned span_c, span_r, iters;
    for (phase = 0; phase < 11; phase++) begin
      span_c = $urandom_range(16, 4095);
      span_r = $urandom_range(16, 4095);
      iters  = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 80);
      if (phase == 0) begin
        set_view($urandom, $urandom, $urandom, $urandom,
                 ($urandom & 32'hFFFF_0000) | $urandom_range(1, 300));
      end else begin
        set_view(32'(-603979776 + int'($urandom_range(0, 1 << 26)) - (1 << 25)),
                 32'(402653184 + int'($urandom_range(0, 1 << 26)) - (1 << 25)),
                 ($urandom & 32'h8000_0000) | (805306368 / span_c),
                 ($urandom & 32'h8000_0000) | (805306368 / span_r),
                 ($urandom & 32'hFFFF_0000) | iters);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      for (k = 0; k < 50; k++) begin
        if ($urandom_range(0, 19) == 0) drain();
        if (phase != 0 && $urandom_range(0, 3) != 0)
          send_pixel(12'($urandom_range(0, span_c)), 12'($urandom_range(0, span_r)));
        else
          send_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_view();
    test_iteration_limit();
    test_radius_boundary();
    test_coord_extremes();
    test_unused_index();
    test_random_views();
    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TIMEOUT at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/metp_pkg.sv
rtl/metp_shade_div.sv
rtl/metp_datapath.sv
rtl/metp_ctrl.sv
rtl/mandelbrot_escape_time_pixel.sv
verif/testbench.sv
